>>> rtl/mpmc_pkg.sv
// Shared types and constants for the multi-pattern match counter.
// Holds trie sizes, item kind codes, the command struct and the row address helper.
// No dependencies.
`default_nettype none
package mpmc_pkg;

  localparam int NODES      = 2048;
  localparam int NODE_W     = 11;
  localparam int ALPHA      = 26;
  localparam int GOTO_DEPTH = NODES * ALPHA;
  localparam int GIDX_W     = 16;
  localparam int MAX_PAT    = 32;
  localparam int MAX_LEN    = 64;
  localparam int LEN_W      = 7;
  localparam int CNT_W      = 24;
  localparam int PTR_W      = 12;

  localparam logic [2:0] KIND_LOAD   = 3'd0;
  localparam logic [2:0] KIND_BUILD  = 3'd1;
  localparam logic [2:0] KIND_SCAN   = 3'd2;
  localparam logic [2:0] KIND_REPORT = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  localparam logic RES_COUNT = 1'b0;
  localparam logic RES_ID    = 1'b1;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_BUILD,
    OP_SCAN,
    OP_REPORT,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] symbol;
    logic [5:0] pattern_id;
    logic       last_symbol;
    logic       sym_ok;
  } cmd_t;

  // Start of a node's row in the flat transition memory: node * 26.
  function automatic logic [GIDX_W-1:0] row_base(input logic [NODE_W-1:0] n);
    logic [GIDX_W-1:0] w;
    w = GIDX_W'(n);
    return (w << 4) + (w << 3) + (w << 1);
  endfunction

endpackage
`default_nettype wire

>>> rtl/multi_pattern_match_counter.sv
// Top level of the multi-pattern match counter.
// Depends on mpmc_pkg, mpmc_front and mpmc_engine.
//
// Usage:
//   s_* carries items: tuser = kind (0 pattern letter, 1 build, 2 text letter,
//   3 report, 4 clear), tdata = symbol and pattern id, tlast = last letter of
//   a pattern. Kinds 5 to 7 are accepted and dropped.
//   m_* carries report results: tuser = 0 for the highest count, 1 for a
//   pattern id; tdata = value and overflow flag; tlast on the final result.
// Operation:
//   A text letter walks its failure chain, each step one read of the link
//   memories. A build visits each node in breadth-first order and each of its
//   letters. A report makes two passes over the pattern ids up to the highest
//   one loaded, both through the single count memory read port.
//   A two-entry command queue lets items be taken while the engine works.
// Reset and clear:
//   Reset and a clear item start a sweep that zeroes the 53248-entry transition
//   memory; items are queued but not executed until it ends.
// Stalls:
//   A stalled receiver holds the result register and the report waits.
`default_nettype none
module multi_pattern_match_counter (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // symbol[4:0], pattern_id[10:5], zero pad
  input  wire  [2:0]  s_tuser,   // kind[2:0]
  input  wire         s_tlast,   // last_symbol
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // value[23:0], overflow[24], zero pad
  output logic        m_tuser,   // item_kind
  output logic        m_tlast    // last
);
  import mpmc_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  mpmc_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .cmd_valid, .cmd, .cmd_pop
  );

  mpmc_engine u_engine (
    .clk, .rst, .cmd_valid, .cmd, .cmd_pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

endmodule
`default_nettype wire

>>> rtl/mpmc_front.sv
// Front end: accepts stream items, classifies them and queues commands.
// Depends on mpmc_pkg. Feeds mpmc_engine through a two-entry queue.
`default_nettype none
module mpmc_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [15:0]         s_tdata,   // symbol[4:0], pattern_id[10:5], zero pad
  input  wire  [2:0]          s_tuser,   // kind[2:0]
  input  wire                 s_tlast,   // last_symbol
  output logic                cmd_valid,
  output mpmc_pkg::cmd_t      cmd,
  input  wire                 cmd_pop
);
  import mpmc_pkg::*;

  cmd_t       slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  cmd_t       incoming;
  logic       known;
  logic       push;

  always_comb begin
    incoming.symbol      = s_tdata[4:0];
    incoming.pattern_id  = s_tdata[10:5];
    incoming.last_symbol = s_tlast;
    incoming.sym_ok      = (s_tdata[4:0] < 5'(ALPHA));
    known                = 1'b1;
    case (s_tuser)
      KIND_LOAD:   incoming.op = OP_LOAD;
      KIND_BUILD:  incoming.op = OP_BUILD;
      KIND_SCAN:   incoming.op = OP_SCAN;
      KIND_REPORT: incoming.op = OP_REPORT;
      KIND_CLEAR:  incoming.op = OP_CLEAR;
      default: begin
        incoming.op = OP_LOAD;
        known       = 1'b0;
      end
    endcase
  end

  assign s_tready  = (fill != 2'd2);
  // drop unknown kinds at the door
  assign push      = s_tvalid && s_tready && known;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (cmd_pop) begin
        rp <= ~rp;
      end
      fill <= fill + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/mpmc_engine.sv
// Back end: trie memories, failure-link build, text scan, report and clear sweep.
// Depends on mpmc_pkg. Takes commands from mpmc_front, drives the result register.
`default_nettype none
module mpmc_engine (
  input  wire             clk,
  input  wire             rst,
  input  wire             cmd_valid,
  input  mpmc_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  output logic            m_tvalid,
  input  wire             m_tready,
  output logic [31:0]     m_tdata,   // value[23:0], overflow[24], zero pad
  output logic            m_tuser,   // item_kind
  output logic            m_tlast    // last
);
  import mpmc_pkg::*;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_LD_WR, ST_BR_RD, ST_BR_WR, ST_BPOP, ST_BU, ST_BFU,
    ST_BROW_RD, ST_BROW_WR, ST_SC_NODE, ST_SC_WALK, ST_SC_HIT, ST_SC_INC,
    ST_RP_RD, ST_RP_CMP, ST_RP_CNT, ST_RP_IRD, ST_RP_ICHK
  } state_t;

  localparam logic [CNT_W-1:0] CEIL = '1;

  // memories
  logic [NODE_W-1:0] gmem [GOTO_DEPTH];
  logic [NODE_W-1:0] fmem [NODES];
  logic [5:0]        pmem [NODES];
  logic [CNT_W-1:0]  cmem [MAX_PAT];
  logic [NODE_W-1:0] qmem [NODES];

  logic [GIDX_W-1:0] g_ra_a, g_ra_b, g_wa;
  logic [NODE_W-1:0] g_rd_a, g_rd_b, g_wd;
  logic              g_we;
  logic [NODE_W-1:0] f_ra, f_wa, f_rd, f_wd;
  logic              f_we;
  logic [NODE_W-1:0] p_ra, p_wa;
  logic [5:0]        p_rd, p_wd;
  logic              p_we;
  logic [4:0]        c_ra, c_wa;
  logic [CNT_W-1:0]  c_rd, c_wd;
  logic              c_we;
  logic [NODE_W-1:0] q_ra, q_wa, q_rd, q_wd;
  logic              q_we;

  // control registers
  state_t            state;
  logic [GIDX_W-1:0] sweep;
  logic [NODE_W-1:0] cur, ins, nfree, u, fu, t;
  logic [5:0]        hi, it_id, ri, lastidx;
  logic [4:0]        it_sym, cidx;
  logic              it_last, ovf, built, disc;
  logic [LEN_W-1:0]  len;
  logic [PTR_W-1:0]  head, tail, steps;
  logic [CNT_W-1:0]  best;

  logic              slot_free;
  logic              emit;
  logic              ld_new, ld_full, ld_drop, it_id_ok, hit_ok;
  logic [NODE_W-1:0] ld_node;

  assign slot_free = !m_tvalid || m_tready;
  assign emit      = slot_free && ((state == ST_RP_CNT) ||
                                   (state == ST_RP_ICHK && c_rd == best));
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;
  assign ld_new    = (g_rd_a == '0);
  assign ld_full   = (nfree == NODE_W'(NODES - 1));
  assign ld_drop   = ld_new && ld_full;
  assign ld_node   = ld_new ? nfree + 1'b1 : g_rd_a;
  assign it_id_ok  = (it_id >= 6'd1) && (it_id <= 6'(MAX_PAT));
  assign hit_ok    = (p_rd >= 6'd1) && (p_rd <= 6'(MAX_PAT));

  // memory ports
  always_comb begin
    g_ra_a = row_base(u) + GIDX_W'(cidx);
    g_ra_b = row_base(fu) + GIDX_W'(cidx);
    g_we = 1'b0; g_wa = g_ra_a; g_wd = '0;
    f_ra = t; f_we = 1'b0; f_wa = g_rd_a; f_wd = '0;
    p_ra = t; p_we = 1'b0; p_wa = ld_node; p_wd = it_id;
    c_ra = ri[4:0] - 5'd1; c_we = 1'b0; c_wa = c_ra; c_wd = c_rd + 1'b1;
    q_ra = head[NODE_W-1:0]; q_we = 1'b0; q_wa = tail[NODE_W-1:0]; q_wd = g_rd_a;
    case (state)
      ST_CLR: begin
        g_we = 1'b1; g_wa = sweep;
        f_we = (sweep < GIDX_W'(NODES)); f_wa = sweep[NODE_W-1:0];
        p_we = f_we; p_wa = sweep[NODE_W-1:0]; p_wd = '0;
        c_we = (sweep < GIDX_W'(MAX_PAT)); c_wa = sweep[4:0]; c_wd = '0;
      end
      ST_IDLE: begin
        g_ra_a = row_base(cmd.op == OP_LOAD ? ins : cur) + GIDX_W'(cmd.symbol);
      end
      ST_LD_WR: begin
        g_we = ld_new && !ld_full;
        g_wa = row_base(ins) + GIDX_W'(it_sym);
        g_wd = nfree + 1'b1;
        p_we = it_last && !ld_drop && it_id_ok;
      end
      ST_BR_RD: g_ra_a = GIDX_W'(cidx);
      ST_BR_WR: begin
        f_we = (g_rd_a != '0);
        q_we = (g_rd_a != '0) && (tail != PTR_W'(NODES));
      end
      ST_BU: f_ra = q_rd;
      ST_BROW_WR: begin
        f_we = (g_rd_a != '0); f_wd = g_rd_b;
        q_we = (g_rd_a != '0) && (tail != PTR_W'(NODES));
        g_we = (g_rd_a == '0); g_wd = g_rd_b;
      end
      ST_SC_HIT: c_ra = p_rd[4:0] - 5'd1;
      ST_SC_INC: begin
        c_ra = it_id[4:0] - 5'd1;
        c_wa = c_ra;
        c_we = (c_rd != CEIL);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    g_rd_a <= gmem[g_ra_a];
    g_rd_b <= gmem[g_ra_b];
    if (g_we) gmem[g_wa] <= g_wd;
  end

  always_ff @(posedge clk) begin
    f_rd <= fmem[f_ra];
    if (f_we) fmem[f_wa] <= f_wd;
    p_rd <= pmem[p_ra];
    if (p_we) pmem[p_wa] <= p_wd;
  end

  always_ff @(posedge clk) begin
    c_rd <= cmem[c_ra];
    if (c_we) cmem[c_wa] <= c_wd;
    q_rd <= qmem[q_ra];
    if (q_we) qmem[q_wa] <= q_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR; sweep <= '0;
      cur <= '0; ins <= '0; nfree <= '0; hi <= '0;
      ovf <= 1'b0; built <= 1'b0; len <= '0; disc <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == GIDX_W'(GOTO_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            it_sym <= cmd.symbol; it_id <= cmd.pattern_id; it_last <= cmd.last_symbol;
            case (cmd.op)
              OP_LOAD: begin
                if (!built && cmd.sym_ok) begin
                  if (!disc && len < LEN_W'(MAX_LEN)) begin
                    state <= ST_LD_WR;
                  end else begin
                    if (!disc) ovf <= 1'b1;
                    disc <= !cmd.last_symbol;
                    if (cmd.last_symbol) begin
                      ins <= '0; len <= '0;
                    end
                  end
                end
              end
              OP_BUILD: begin
                if (!built) begin
                  cidx <= '0; head <= '0; tail <= '0;
                  state <= ST_BR_RD;
                end
              end
              OP_SCAN: begin
                if (cmd.sym_ok) state <= ST_SC_NODE;
                else cur <= '0;
              end
              OP_REPORT: begin
                best <= '0; lastidx <= '0; ri <= 6'd1;
                state <= (hi == '0) ? ST_RP_CNT : ST_RP_RD;
              end
              OP_CLEAR: begin
                sweep <= '0; cur <= '0; ins <= '0; nfree <= '0; hi <= '0;
                ovf <= 1'b0; built <= 1'b0; len <= '0; disc <= 1'b0;
                state <= ST_CLR;
              end
              default: ;
            endcase
          end
        end
        ST_LD_WR: begin
          if (ld_drop) begin
            ovf <= 1'b1;
          end else if (ld_new) begin
            nfree <= nfree + 1'b1;
          end
          if (it_last) begin
            if (!ld_drop && it_id_ok && it_id > hi) hi <= it_id;
            ins <= '0; len <= '0; disc <= 1'b0;
          end else begin
            disc <= ld_drop;
            if (!ld_drop) begin
              ins <= ld_node; len <= len + 1'b1;
            end
          end
          state <= ST_IDLE;
        end
        ST_BR_RD: state <= ST_BR_WR;
        ST_BR_WR: begin
          if (g_rd_a != '0 && tail != PTR_W'(NODES)) tail <= tail + 1'b1;
          if (cidx == 5'(ALPHA - 1)) begin
            if (head < tail || (g_rd_a != '0)) state <= ST_BPOP;
            else begin
              built <= 1'b1; state <= ST_IDLE;
            end
          end else begin
            cidx <= cidx + 1'b1; state <= ST_BR_RD;
          end
        end
        ST_BPOP: begin
          head <= head + 1'b1; state <= ST_BU;
        end
        ST_BU: begin
          u <= q_rd; state <= ST_BFU;
        end
        ST_BFU: begin
          fu <= f_rd; cidx <= '0; state <= ST_BROW_RD;
        end
        ST_BROW_RD: state <= ST_BROW_WR;
        ST_BROW_WR: begin
          if (g_rd_a != '0 && tail != PTR_W'(NODES)) tail <= tail + 1'b1;
          if (cidx == 5'(ALPHA - 1)) begin
            if (head < tail || (g_rd_a != '0)) state <= ST_BPOP;
            else begin
              built <= 1'b1; state <= ST_IDLE;
            end
          end else begin
            cidx <= cidx + 1'b1; state <= ST_BROW_RD;
          end
        end
        ST_SC_NODE: begin
          cur <= g_rd_a; t <= g_rd_a; steps <= '0;
          state <= (g_rd_a == '0) ? ST_IDLE : ST_SC_WALK;
        end
        ST_SC_WALK: begin
          steps <= steps + 1'b1; state <= ST_SC_HIT;
        end
        ST_SC_HIT: begin
          t <= f_rd; it_id <= p_rd;
          if (hit_ok) state <= ST_SC_INC;
          else if (f_rd != '0 && steps != PTR_W'(NODES)) state <= ST_SC_WALK;
          else state <= ST_IDLE;
        end
        ST_SC_INC: begin
          state <= (t != '0 && steps != PTR_W'(NODES)) ? ST_SC_WALK : ST_IDLE;
        end
        ST_RP_RD: state <= ST_RP_CMP;
        ST_RP_CMP: begin
          if (c_rd > best) begin
            best <= c_rd; lastidx <= ri;
          end else if (c_rd == best) begin
            lastidx <= ri;
          end
          if (ri == hi) begin
            ri <= 6'd1; state <= ST_RP_CNT;
          end else begin
            ri <= ri + 1'b1; state <= ST_RP_RD;
          end
        end
        ST_RP_CNT: begin
          if (slot_free) begin
            m_tuser <= RES_COUNT;
            m_tdata <= {7'd0, ovf, best}; m_tlast <= (hi == '0);
            state <= (hi == '0) ? ST_IDLE : ST_RP_IRD;
          end
        end
        ST_RP_IRD: state <= ST_RP_ICHK;
        ST_RP_ICHK: begin
          if (c_rd != best || slot_free) begin
            if (c_rd == best) begin
              m_tuser <= RES_ID;
              m_tdata <= {7'd0, ovf, 18'd0, ri}; m_tlast <= (ri == lastidx);
            end
            if (ri == hi) state <= ST_IDLE;
            else begin
              ri <= ri + 1'b1; state <= ST_RP_IRD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/mpmc_checker.sv
// Port checker for the multi-pattern match counter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module mpmc_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [31:0] m_tdata,
  input wire        m_tuser,
  input wire        m_tlast
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:25] == 7'd0)
    else $error("result padding not zero");

  a_id_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[23:6] == 18'd0 && m_tdata[5:0] != 6'd0))
    else $error("pattern id out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind multi_pattern_match_counter mpmc_checker u_mpmc_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);
`default_nettype wire

>>> tb/tb_multi_pattern_match_counter.sv
// Self-checking testbench for multi_pattern_match_counter: a directed table and random rounds,
// all checked against an Aho-Corasick predictor kept inside the bench, but for two typed-in reports.
// Depends on mpmc_pkg and the multi_pattern_match_counter RTL.
`default_nettype none
module tb_multi_pattern_match_counter;
  timeunit 1ns;
  timeprecision 1ps;
  import mpmc_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE = 400;
  localparam int unsigned CNT_CEIL = (1 << CNT_W) - 1;

  typedef struct {
    logic [2:0] kind;
    logic [4:0] symbol;
    logic [5:0] pid;
    logic       lastsym;
    bit         fixed;      // expected report typed in below
    int         fixed_cnt;
  } stim_t;

  typedef struct {
    logic        rkind;
    logic [23:0] value;
    logic        last;
    logic        ovf;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  multi_pattern_match_counter dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // Aho-Corasick shadow state
  bit [NODE_W-1:0] trie_next [NODES][ALPHA];
  bit [NODE_W-1:0] fail_to [NODES];
  bit [5:0] end_id [NODES];
  int unsigned pat_hits [MAX_PAT+1];
  int bfs_order [NODES];
  int cur_node, ins_node, top_node, top_id, pat_len;
  bit trie_ovf, trie_linked, pat_dropped;

  result_t report_q[$];
  int send_idle_pct, recv_idle_pct;
  int mismatches;
  int cycles;

  function automatic void wipe_matcher();
    foreach (trie_next[n, c]) trie_next[n][c] = '0;
    foreach (fail_to[n]) begin
      fail_to[n] = '0;
      end_id[n] = '0;
    end
    foreach (pat_hits[i]) pat_hits[i] = 0;
    cur_node = 0; ins_node = 0; top_node = 0; top_id = 0; pat_len = 0;
    trie_ovf = 1'b0; trie_linked = 1'b0; pat_dropped = 1'b0;
  endfunction

  function automatic void insert_letter(int sym, int id, bit fin);
    int nxt;
    if (trie_linked || sym >= ALPHA) return;
    if (!pat_dropped) begin
      if (pat_len >= MAX_LEN) begin
        pat_dropped = 1'b1;
        trie_ovf = 1'b1;
      end else begin
        nxt = trie_next[ins_node][sym];
        if (nxt == 0) begin
          if (top_node + 1 >= NODES) begin
            pat_dropped = 1'b1;
            trie_ovf = 1'b1;
          end else begin
            top_node++;
            trie_next[ins_node][sym] = NODE_W'(top_node);
            nxt = top_node;
          end
        end
        if (!pat_dropped) begin
          ins_node = nxt;
          pat_len++;
        end
      end
    end
    if (fin) begin
      if (!pat_dropped && id >= 1 && id <= MAX_PAT) begin
        end_id[ins_node] = 6'(id);
        if (id > top_id) top_id = id;
      end
      ins_node = 0;
      pat_len = 0;
      pat_dropped = 1'b0;
    end
  endfunction

  function automatic void link_trie();
    int head, tail, u, fu, v, f;
    head = 0;
    tail = 0;
    if (trie_linked) return;
    for (int c = 0; c < ALPHA; c++) begin
      v = trie_next[0][c];
      if (v != 0 && tail < NODES) begin
        fail_to[v] = '0;
        bfs_order[tail++] = v;
      end
    end
    while (head < tail) begin
      u = bfs_order[head++];
      fu = fail_to[u];
      for (int c = 0; c < ALPHA; c++) begin
        v = trie_next[u][c];
        f = trie_next[fu][c];
        if (v != 0) begin
          fail_to[v] = NODE_W'(f);
          if (tail < NODES) bfs_order[tail++] = v;
        end else begin
          trie_next[u][c] = NODE_W'(f);
        end
      end
    end
    trie_linked = 1'b1;
  endfunction

  function automatic void scan_letter(int sym);
    int t, steps, id;
    steps = 0;
    if (sym >= ALPHA) begin
      cur_node = 0;
      return;
    end
    cur_node = trie_next[cur_node][sym];
    t = cur_node;
    while (t != 0 && steps < NODES) begin
      id = end_id[t];
      if (id >= 1 && id <= MAX_PAT && pat_hits[id] < CNT_CEIL) pat_hits[id]++;
      t = fail_to[t];
      steps++;
    end
  endfunction

  function automatic void predict_report();
    int unsigned best;
    result_t r;
    result_t run[$];
    best = 0;
    for (int i = 1; i <= top_id && i <= MAX_PAT; i++)
      if (pat_hits[i] > best) best = pat_hits[i];
    r.rkind = RES_COUNT; r.value = 24'(best); r.last = 0; r.ovf = trie_ovf;
    run.push_back(r);
    for (int i = 1; i <= top_id && i <= MAX_PAT; i++)
      if (pat_hits[i] == best) begin
        r.rkind = RES_ID; r.value = 24'(i);
        run.push_back(r);
      end
    run[run.size()-1].last = 1;
    foreach (run[k]) report_q.push_back(run[k]);
  endfunction

  function automatic void apply_item(stim_t it);
    result_t r;
    case (it.kind)
      KIND_LOAD:   insert_letter(it.symbol, it.pid, it.lastsym);
      KIND_BUILD:  link_trie();
      KIND_SCAN:   scan_letter(it.symbol);
      KIND_REPORT: begin
        if (it.fixed) begin
          r.rkind = RES_COUNT; r.value = 24'(it.fixed_cnt); r.last = 1; r.ovf = 0;
          report_q.push_back(r);
        end else begin
          predict_report();
        end
      end
      KIND_CLEAR:  wipe_matcher();
      default: ;
    endcase
  endfunction

  task automatic send(stim_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.kind;
    s_tdata <= {5'b0, it.pid, it.symbol};
    s_tlast <= it.lastsym;
    do @(posedge clk); while (!s_tready);
    apply_item(it);
  endtask

  task automatic send_fields(int kind, int sym, int id, int fin);
    stim_t it;
    it.kind = 3'(kind); it.symbol = 5'(sym); it.pid = 6'(id); it.lastsym = 1'(fin);
    it.fixed = 0; it.fixed_cnt = 0;
    send(it);
  endtask

  function automatic int pick_symbol();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 31);
    return $urandom_range(0, 3);
  endfunction

  function automatic int pick_id();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 63);
    return $urandom_range(1, 32);
  endfunction

  // One random round: clear, patterns, mostly a build, text with reports and noise sprinkled in.
  task automatic random_round();
    int npat, plen, ntext;
    send_fields(KIND_CLEAR, $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 1));
    npat = $urandom_range(1, 6);
    for (int p = 0; p < npat; p++) begin
      plen = ($urandom_range(0, 15) == 0) ? 66 : $urandom_range(1, 5);
      for (int k = 0; k < plen; k++)
        send_fields(KIND_LOAD, pick_symbol(), pick_id(), k == plen - 1);
      if ($urandom_range(0, 9) == 0)
        send_fields($urandom_range(5, 7), $urandom_range(0, 31), $urandom_range(0, 63),
                    $urandom_range(0, 1));
    end
    if ($urandom_range(0, 5) != 0) send_fields(KIND_BUILD, 0, 0, 0);
    ntext = $urandom_range(15, 35);
    for (int k = 0; k < ntext; k++) begin
      case ($urandom_range(0, 19))
        0: send_fields(KIND_LOAD, pick_symbol(), pick_id(), $urandom_range(0, 1));
        1: send_fields(KIND_REPORT, $urandom_range(0, 31), $urandom_range(0, 63), 0);
        2: send_fields($urandom_range(5, 7), $urandom_range(0, 31), $urandom_range(0, 63), 1);
        3: send_fields(KIND_BUILD, $urandom_range(0, 31), $urandom_range(0, 63), 0);
        default: send_fields(KIND_SCAN, pick_symbol(), $urandom_range(0, 63),
                             $urandom_range(0, 1));
      endcase
    end
    send_fields(KIND_REPORT, 0, 0, 0);
  endtask

  stim_t directed [] = '{
    '{KIND_REPORT, 5'd0,  6'd0,  1'b0, 1, 0},   // empty matcher reports count 0
    '{KIND_LOAD,   5'd0,  6'd1,  1'b0, 0, 0},
    '{KIND_LOAD,   5'd1,  6'd1,  1'b1, 0, 0},   // "ab" as id 1
    '{KIND_LOAD,   5'd1,  6'd32, 1'b1, 0, 0},   // "b" as top id
    '{KIND_LOAD,   5'd2,  6'd0,  1'b1, 0, 0},   // id 0 never recorded
    '{KIND_LOAD,   5'd27, 6'd5,  1'b1, 0, 0},   // bad letter ignored
    '{KIND_LOAD,   5'd25, 6'd63, 1'b1, 0, 0},   // id out of range
    '{3'd5,        5'd31, 6'd63, 1'b1, 0, 0},
    '{3'd7,        5'd0,  6'd0,  1'b0, 0, 0},
    '{KIND_SCAN,   5'd0,  6'd0,  1'b0, 0, 0},   // text on bare trie
    '{KIND_SCAN,   5'd1,  6'd0,  1'b0, 0, 0},
    '{KIND_BUILD,  5'd0,  6'd0,  1'b0, 0, 0},
    '{KIND_BUILD,  5'd0,  6'd0,  1'b0, 0, 0},   // second build does nothing
    '{KIND_LOAD,   5'd0,  6'd2,  1'b1, 0, 0},   // too late, trie is linked
    '{KIND_SCAN,   5'd0,  6'd0,  1'b0, 0, 0},
    '{KIND_SCAN,   5'd1,  6'd0,  1'b0, 0, 0},
    '{KIND_SCAN,   5'd1,  6'd0,  1'b0, 0, 0},
    '{KIND_SCAN,   5'd31, 6'd0,  1'b0, 0, 0},   // bad letter back to root
    '{KIND_SCAN,   5'd1,  6'd0,  1'b0, 0, 0},
    '{KIND_SCAN,   5'd25, 6'd0,  1'b0, 0, 0},
    '{KIND_REPORT, 5'd0,  6'd0,  1'b0, 0, 0},
    '{KIND_CLEAR,  5'd0,  6'd0,  1'b0, 0, 0},
    '{KIND_REPORT, 5'd0,  6'd0,  1'b0, 1, 0}
  };

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: kind %0d value %0d", m_tuser,
                                       m_tdata[23:0]);
      end else begin
        want = report_q.pop_front();
        if (m_tuser !== want.rkind || m_tdata[23:0] !== want.value || m_tlast !== want.last
            || m_tdata[24] !== want.ovf || m_tdata[31:25] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want kind %0d value %0d last %0d ovf %0d, got %0d %0d %0d %0d",
                     want.rkind, want.value, want.last, want.ovf,
                     m_tuser, m_tdata[23:0], m_tlast, m_tdata[24]);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    send_idle_pct = 10;
    recv_idle_pct = 79;
    wipe_matcher();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send(directed[i]);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 79 : 0;
      recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 10 : 0;
      for (int r = 0; r < 3; r++) random_round();
    end
    s_tvalid <= 1'b0;

    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
rtl/mpmc_pkg.sv
rtl/mpmc_front.sv
rtl/mpmc_engine.sv
rtl/multi_pattern_match_counter.sv
rtl/mpmc_checker.sv
tb/tb_multi_pattern_match_counter.sv
